/* rtl/lru_key_value_cache_defines.svh */
// assertion macros for the lru key-value cache
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
`define LKV_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LKV_ASSERT_ALWAYS(label, expr, msg)
`define LKV_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/lkv_pkg.sv */
// types and constants shared by the lru key-value cache
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W  = IDX_W;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int DATA_W  = 32;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE     = '1;

   typedef enum logic {
      FUNC_LOOKUP = 1'b0,
      FUNC_STORE  = 1'b1
   } func_type;

   typedef struct packed {
      func_type           func;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]   fill_count;
      logic [ENTRIES-1:0] valid_vec;
   } status_type;

endpackage

/* rtl/lru_key_value_cache.sv */
// Fully associative 16-entry key-value cache with least-recently-used
// replacement. A transaction is a lookup or a store; each gives exactly one
// response. One transaction is taken per clock while the response side does
// not stall: it sits in the input register while all keys are compared in
// parallel and the recency ranks are updated, and its response is registered
// as the transaction leaves the input register, so the throughput is
// one transaction per cycle as long as the response side does not stall. The
// capacity register may only be written while no transaction is in flight;
// values of zero act as one and values above sixteen act as sixteen.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lkv_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lkv_pkg::rsp_type          rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0] csr_data
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   lkv_pkg::req_type          in_req_ff;
   lkv_pkg::req_type          in_req_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   lkv_pkg::rsp_type          rsp_ff;
   lkv_pkg::rsp_type          rsp_in;
   logic [lkv_pkg::CAP_W-1:0] cap_ff;
   logic [lkv_pkg::CAP_W-1:0] cap_in;
   logic                      out_busy;
   logic                      advance;
   lkv_pkg::rsp_type          result;
   lkv_pkg::status_type       status;

   lkv_store u_store (
      .clock    (clock),
      .reset    (reset),
      .op_en    (advance),
      .op       (in_req_ff),
      .capacity (cap_ff),
      .result   (result),
      .status   (status)
   );

   always_comb begin
      out_busy  = rsp_valid_ff && rsp_stall;
      advance   = in_valid_ff && !out_busy;
      req_stall = in_valid_ff && out_busy;

      in_valid_in = in_valid_ff;
      in_req_in   = in_req_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_req_in   = req_payload;
      end

      rsp_valid_in = advance || out_busy;
      rsp_in       = advance ? result : rsp_ff;

      cap_in = (csr_valid && csr_ready) ? csr_data : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lkv_pkg::CAPACITY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
      rsp_ff    <= rsp_in;
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `LKV_ASSERT_NEXT(a_advance_gives_rsp, advance, rsp_valid,
      "advanced transaction lost its response")
   `LKV_ASSERT_ALWAYS(a_fill_matches_valid,
      $countones(status.valid_vec) == status.fill_count,
      "fill count disagrees with valid entries")
   `LKV_ASSERT_ALWAYS(a_fill_steps_by_one,
      (status.fill_count == $past(status.fill_count)) ||
      (status.fill_count == $past(status.fill_count) + 1'b1),
      "fill count moved by more than one")

endmodule

/* rtl/lkv_store.sv */
// entry registers with parallel key match, replacement choice and recency update
module lkv_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       op_en,
   input  lkv_pkg::req_type           op,
   input  logic [lkv_pkg::CAP_W-1:0]  capacity,
   output lkv_pkg::rsp_type           result,
   output lkv_pkg::status_type        status
);

   logic [lkv_pkg::DATA_W-1:0]  key_ff   [lkv_pkg::ENTRIES];
   logic [lkv_pkg::DATA_W-1:0]  key_in   [lkv_pkg::ENTRIES];
   logic [lkv_pkg::DATA_W-1:0]  value_ff [lkv_pkg::ENTRIES];
   logic [lkv_pkg::DATA_W-1:0]  value_in [lkv_pkg::ENTRIES];
   logic [lkv_pkg::RANK_W-1:0]  rank_ff  [lkv_pkg::ENTRIES];
   logic [lkv_pkg::RANK_W-1:0]  rank_in  [lkv_pkg::ENTRIES];
   logic [lkv_pkg::ENTRIES-1:0] valid_ff;
   logic [lkv_pkg::ENTRIES-1:0] valid_in;
   logic [lkv_pkg::CNT_W-1:0]   fill_count_ff;
   logic [lkv_pkg::CNT_W-1:0]   fill_count_in;

   logic [lkv_pkg::ENTRIES-1:0] hit_vec;
   logic [lkv_pkg::ENTRIES-1:0] free_vec;
   logic [lkv_pkg::ENTRIES-1:0] victim_vec;
   logic [lkv_pkg::ENTRIES-1:0] target_vec;
   logic [lkv_pkg::ENTRIES-1:0] invalid_vec;
   logic                        hit;
   logic [lkv_pkg::DATA_W-1:0]  hit_value;
   logic [lkv_pkg::RANK_W-1:0]  hit_rank;
   logic [lkv_pkg::RANK_W-1:0]  oldest_rank;
   logic [lkv_pkg::CMP_W-1:0]   cap_ext;
   logic [lkv_pkg::CMP_W-1:0]   eff_cap;
   logic                        fill;
   logic                        is_store;
   logic                        do_update;

   // match and choose
   always_comb begin
      hit_vec     = '0;
      victim_vec  = '0;
      hit_value   = '0;
      hit_rank    = '0;
      oldest_rank = lkv_pkg::RANK_W'(fill_count_ff - 1'b1);
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
         hit_vec[i]    = valid_ff[i] && (key_ff[i] == op.key);
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
         hit_value     = hit_value | (hit_vec[i] ? value_ff[i] : '0);
         hit_rank      = hit_rank | (hit_vec[i] ? rank_ff[i] : '0);
      end
      hit         = |hit_vec;
      invalid_vec = ~valid_ff;
      free_vec    = invalid_vec & (~invalid_vec + 1'b1);

      cap_ext = lkv_pkg::CMP_W'(capacity);
      if (cap_ext == '0) begin
         eff_cap = lkv_pkg::CMP_W'(1);
      end else if (cap_ext > lkv_pkg::CMP_W'(lkv_pkg::ENTRIES)) begin
         eff_cap = lkv_pkg::CMP_W'(lkv_pkg::ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      fill = (lkv_pkg::CMP_W'(fill_count_ff) < eff_cap) &&
             (fill_count_ff < lkv_pkg::CNT_W'(lkv_pkg::ENTRIES));

      priority if (hit) begin
         target_vec = hit_vec;
      end else if (fill) begin
         target_vec = free_vec;
      end else begin
         target_vec = victim_vec;
      end

      is_store  = (op.func == lkv_pkg::FUNC_STORE);
      do_update = op_en && (hit || is_store);
   end

   // result
   always_comb begin
      result.hit = hit;
      if (is_store) begin
         result.read_value = op.value;
      end else if (hit) begin
         result.read_value = hit_value;
      end else begin
         result.read_value = lkv_pkg::MISS_VALUE;
      end
   end

   // next state
   always_comb begin
      valid_in      = valid_ff;
      fill_count_in = fill_count_ff;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         rank_in[i]  = rank_ff[i];
         if (do_update) begin
            if (target_vec[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (!hit || (rank_ff[i] < hit_rank))) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         if (op_en && is_store && target_vec[i]) begin
            value_in[i] = op.value;
            key_in[i]   = op.key;
            if (!hit && fill) begin
               valid_in[i] = 1'b1;
            end
         end
      end
      if (op_en && is_store && !hit && fill) begin
         fill_count_in = fill_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         fill_count_ff <= '0;
      end else begin
         valid_ff      <= valid_in;
         fill_count_ff <= fill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

   assign status.fill_count = fill_count_ff;
   assign status.valid_vec  = valid_ff;

endmodule

/* dv/lru_key_value_cache_tb.sv */
// self-checking testbench for the lru key-value cache: directed table, then random phases
module lru_key_value_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PERIOD      = 8;
   localparam int          RESET_CYCLES = 5;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          PHASES      = 12;
   localparam int          PHASE_ITEMS = 120;
   localparam int          HOLD_CYCLES = 400;
   localparam int          POOL_MAX    = 24;
   localparam logic [lkv_pkg::CAP_W-1:0] CAP_PLAN [8] = '{
      lkv_pkg::CAP_W'(16), lkv_pkg::CAP_W'(2), lkv_pkg::CAP_W'(0), lkv_pkg::CAP_W'(31),
      lkv_pkg::CAP_W'(1), lkv_pkg::CAP_W'(17), lkv_pkg::CAP_W'(8), lkv_pkg::CAP_W'(4)
   };

   typedef enum logic {
      ROW_ACCESS   = 1'b0,
      ROW_CAPACITY = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type     kind;
      lkv_pkg::req_type req;
      bit               typed;
      lkv_pkg::rsp_type rsp;
   } directed_row_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   lkv_pkg::req_type             req_payload = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   lkv_pkg::rsp_type             rsp_payload;
   logic                         csr_valid   = 1'b0;
   logic                         csr_ready;
   logic [lkv_pkg::CAP_W-1:0]    csr_data    = lkv_pkg::CAPACITY_RESET;

   // shadow copy of the cache contents
   logic [lkv_pkg::DATA_W-1:0]   line_key   [lkv_pkg::ENTRIES];
   logic [lkv_pkg::DATA_W-1:0]   line_value [lkv_pkg::ENTRIES];
   logic [lkv_pkg::RANK_W-1:0]   line_rank  [lkv_pkg::ENTRIES];
   bit                           line_valid [lkv_pkg::ENTRIES] = '{default: 1'b0};
   int                           fill_count   = 0;
   logic [lkv_pkg::CAP_W-1:0]    capacity_reg = lkv_pkg::CAPACITY_RESET;

   lkv_pkg::rsp_type             pending_rsp_q [$];
   directed_row_type             directed_rows [$];
   int                           mismatch_count = 0;
   int                           burst_left     = 0;
   logic                         hold_request   = 1'b0;
   int unsigned                  cycle_count    = 0;

   lru_key_value_cache DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic void touch_line(input int idx);
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
         if (line_valid[i] && i != idx && line_rank[i] < line_rank[idx]) begin
            line_rank[i] = line_rank[i] + 1'b1;
         end
      end
      line_rank[idx] = '0;
   endfunction

   function automatic lkv_pkg::rsp_type cache_access(input lkv_pkg::req_type item);
      lkv_pkg::rsp_type result;
      int               slot;
      int               victim;
      int               limit;
      slot   = -1;
      victim = -1;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
         if (slot < 0 && line_valid[i] && line_key[i] == item.key) begin
            slot = i;
         end
      end
      if (item.func == lkv_pkg::FUNC_LOOKUP) begin
         result.hit        = (slot >= 0);
         result.read_value = (slot >= 0) ? line_value[slot] : lkv_pkg::MISS_VALUE;
         if (slot >= 0) begin
            touch_line(slot);
         end
      end else begin
         result.hit        = (slot >= 0);
         result.read_value = item.value;
         limit = (capacity_reg == 0) ? 1 :
                 (capacity_reg > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : int'(capacity_reg);
         if (slot >= 0) begin
            line_value[slot] = item.value;
            touch_line(slot);
         end else if (fill_count < limit) begin
            for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
               if (!line_valid[i]) begin
                  slot = i;
               end
            end
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
               if (line_valid[i]) begin
                  line_rank[i] = line_rank[i] + 1'b1;
               end
            end
            line_valid[slot] = 1'b1;
            line_key[slot]   = item.key;
            line_value[slot] = item.value;
            line_rank[slot]  = '0;
            fill_count++;
         end else begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
               if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) begin
                  victim = i;
               end
            end
            line_key[victim]   = item.key;
            line_value[victim] = item.value;
            touch_line(victim);
         end
      end
      return result;
   endfunction

   task automatic send_item(input lkv_pkg::req_type item, input bit typed,
                            input lkv_pkg::rsp_type typed_rsp);
      lkv_pkg::rsp_type predicted;
      int               gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(60, 150);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = cache_access(item);
      pending_rsp_q.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      capacity_reg = cap;
      burst_left   = 0;
   endtask

   function automatic void add_row(input row_kind_type kind, input lkv_pkg::func_type func,
                                   input logic [31:0] key, input logic [31:0] value,
                                   input bit typed, input logic hit,
                                   input logic [31:0] read_value);
      directed_row_type row;
      row.kind           = kind;
      row.req.func       = func;
      row.req.key        = key;
      row.req.value      = value;
      row.typed          = typed;
      row.rsp.hit        = hit;
      row.rsp.read_value = read_value;
      directed_rows.push_back(row);
   endfunction

   // response checker
   always @(posedge clock) begin
      lkv_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected response: hit=%0b value=%h",
                        rsp_payload.hit, rsp_payload.read_value);
            end
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_payload.hit !== want.hit || rsp_payload.read_value !== want.read_value) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response differs: expected hit=%0b value=%h, got hit=%0b value=%h",
                           want.hit, want.read_value, rsp_payload.hit, rsp_payload.read_value);
               end
            end
         end
      end
   end

   // receiver stall pattern with one long hold
   int stall_mode      = 0;
   int stall_mode_left = 0;
   int stall_tick      = 0;
   int hold_left       = 0;
   bit hold_done       = 1'b0;

   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (stall_mode_left == 0) begin
         stall_mode      = $urandom_range(0, 3);
         stall_mode_left = $urandom_range(20, 200);
      end
      stall_mode_left--;
      stall_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= (stall_tick % 4 == 3);
            default: rsp_stall <= ($urandom_range(0, 99) < 75);
         endcase
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("lru_key_value_cache: mismatch");
      $finish;
   end

   initial begin
      lkv_pkg::req_type           item;
      logic [lkv_pkg::DATA_W-1:0] key_pool [POOL_MAX];
      int                         pool_size;

      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h1234_5678,
              1'b1, 1'b0, lkv_pkg::MISS_VALUE);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_STORE,  32'h7fff_ffff, 32'h8000_0000,
              1'b1, 1'b0, 32'h8000_0000);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_STORE,  32'h8000_0000, 32'h7fff_ffff,
              1'b1, 1'b0, 32'h7fff_ffff);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_STORE,  32'h0000_0000, 32'hffff_ffff,
              1'b1, 1'b0, 32'hffff_ffff);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h7fff_ffff, 32'h0000_0000,
              1'b1, 1'b1, 32'h8000_0000);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'hffff_ffff, 32'hffff_ffff,
              1'b1, 1'b0, lkv_pkg::MISS_VALUE);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_STORE,  32'h8000_0000, 32'h0000_0000,
              1'b1, 1'b1, 32'h0000_0000);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000,
              1'b1, 1'b1, 32'h0000_0000);
      // capacity zero acts as one, below the current fill
      add_row(ROW_CAPACITY, lkv_pkg::FUNC_LOOKUP, '0, 32'd0, 1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_STORE,  32'h0000_0001, 32'h0000_0005,
              1'b1, 1'b0, 32'h0000_0005);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000,
              1'b1, 1'b0, lkv_pkg::MISS_VALUE);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0000,
              1'b1, 1'b1, 32'h0000_0005);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_STORE,  32'h0000_0002, 32'h0000_0006,
              1'b1, 1'b0, 32'h0000_0006);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h7fff_ffff, 32'h0000_0000,
              1'b0, 1'b0, '0);
      // capacity above the entry count acts as the entry count
      add_row(ROW_CAPACITY, lkv_pkg::FUNC_LOOKUP, '0, 32'd31, 1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_STORE,  32'h0000_0003, 32'h0000_0007,
              1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000,
              1'b0, 1'b0, '0);
      add_row(ROW_CAPACITY, lkv_pkg::FUNC_LOOKUP, '0, 32'd17, 1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_STORE,  32'h0000_0004, 32'h0000_0008,
              1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h0000_0002, 32'h0000_0000,
              1'b0, 1'b0, '0);
      add_row(ROW_CAPACITY, lkv_pkg::FUNC_LOOKUP, '0, 32'd1, 1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_STORE,  32'h1234_5678, 32'h5a5a_5a5a,
              1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h0000_0003, 32'h0000_0000,
              1'b0, 1'b0, '0);
      add_row(ROW_CAPACITY, lkv_pkg::FUNC_LOOKUP, '0, 32'd16, 1'b0, 1'b0, '0);
      add_row(ROW_ACCESS, lkv_pkg::FUNC_LOOKUP, 32'h0000_0004, 32'h0000_0000,
              1'b0, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CAPACITY) begin
            write_capacity(directed_rows[i].req.value[lkv_pkg::CAP_W-1:0]);
         end else begin
            send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         write_capacity((phase < 8) ? CAP_PLAN[phase]
                                    : lkv_pkg::CAP_W'($urandom_range(0, 31)));
         pool_size = $urandom_range(1, POOL_MAX);
         for (int i = 0; i < POOL_MAX; i++) begin
            key_pool[i] = $urandom;
         end
         if (phase == 3) begin
            hold_request <= 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            item.func  = ($urandom_range(0, 1) == 1) ? lkv_pkg::FUNC_STORE
                                                     : lkv_pkg::FUNC_LOOKUP;
            item.key   = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_size - 1)]
                                                      : $urandom;
            item.value = $urandom;
            send_item(item, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("lru_key_value_cache: match");
      end else begin
         $display("lru_key_value_cache: mismatch");
      end
      $finish;
   end

endmodule
